[rtl/sbps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and factor table for the SPI baud prescaler search.
// No dependencies; used by every module of the block.
package sbps_pkg;

	localparam int unsigned DIV_W       = 32;  // dividend and divisor width
	localparam int unsigned QUOT_W      = 18;  // quotient bits resolved by the divider
	localparam int unsigned NEED_W      = 19;  // rounded-up quotient, up to 2**18
	localparam int unsigned RATIO_W     = 18;  // largest product is 7 * 32768
	localparam int unsigned PRE_N       = 4;
	localparam int unsigned SCL_N       = 16;
	localparam int unsigned DIV_STAGES  = 9;   // two quotient bits per stage
	localparam int unsigned BUS_CLK_RST = 100000000;

	localparam logic [1:0] PRE_IDX_MAX = 2'd3;
	localparam logic [3:0] SCL_IDX_MAX = 4'd15;

	typedef struct packed {
		logic [DIV_W-1:0]  divisor;
		logic [DIV_W-1:0]  rem;
		logic [QUOT_W-1:0] low;   // dividend bits not yet shifted in
		logic [QUOT_W-1:0] quot;
		logic              ovf;   // quotient at least 2**18, or zero divisor
	} div_t;

	typedef struct packed {
		logic               ok;
		logic [1:0]         pidx;
		logic [3:0]         sidx;
		logic [RATIO_W-1:0] prod;
	} cand_t;

	typedef struct packed {
		logic [1:0]         prescale_index;
		logic [3:0]         scaler_index;
		logic [RATIO_W-1:0] achieved_ratio;
		logic               no_fit;
	} result_t;

	// scaler factors: 2,4,6,8 then 16..32768; prescaler factors: 2,3,5,7
	function automatic logic [RATIO_W-1:0] pair_product(input logic [3:0] s, input logic [1:0] p);
		logic [RATIO_W-1:0] scl;
		logic [RATIO_W-1:0] pre;
		if (s < 4'd4) begin
			scl = {13'd0, s, 1'b0} + 18'd2;
		end else begin
			scl = 18'd1 << s;
		end
		case (p)
			2'd0:    pre = 18'd2;
			2'd1:    pre = 18'd3;
			2'd2:    pre = 18'd5;
			default: pre = 18'd7;
		endcase
		return scl * pre;
	endfunction

	// a holds the lower scaler index, so it wins ties
	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (b.ok && (!a.ok || (b.prod < a.prod))) begin
			return b;
		end
		return a;
	endfunction

endpackage

[rtl/spi_baud_prescaler_search_core.sv]
`timescale 1ns / 1ps
// SPI baud prescaler search, top level. The pipeline has one capture stage, nine
// divider stages of two quotient bits each and three selection stages. One transfer
// per cycle is sustained while the output is not stalled; any stage that is empty
// takes a new item even while the output is stalled.
// Reset clears all stage valid bits and loads bus_clock_q with 100000000.
// Depends on sbps_pkg, sbps_div_step, sbps_select.
module spi_baud_prescaler_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        target_valid,
	output logic        target_stall,
	input  logic [31:0] target_hz,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  prescale_index,
	output logic [3:0]  scaler_index,
	output logic [17:0] achieved_ratio,
	output logic        no_fit
);

	localparam int unsigned NDIV = sbps_pkg::DIV_STAGES;
	localparam int unsigned NST  = NDIV + 4;   // capture + divider + three select

	logic [31:0]       bus_clock_q;
	logic [NST-1:0]    vld_s;
	logic [NST-1:0]    adv;
	sbps_pkg::div_t    div_s [NDIV+1];
	sbps_pkg::div_t    cap;
	sbps_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clock_q <= 32'(sbps_pkg::BUS_CLK_RST);
		end else if (cfg_write) begin
			bus_clock_q <= cfg_data;
		end
	end

	// a stage advances when it is empty or its successor advances
	always_comb begin
		adv[NST-1] = !vld_s[NST-1] || !result_stall;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign target_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= target_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// top 14 dividend bits below the divisor means no subtraction there yet
	always_comb begin
		cap.divisor = target_hz;
		cap.rem     = {18'd0, bus_clock_q[31:18]};
		cap.low     = bus_clock_q[17:0];
		cap.quot    = '0;
		cap.ovf     = ({18'd0, bus_clock_q[31:18]} >= target_hz);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			div_s[0] <= cap;
		end
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		sbps_div_step u_step (
			.clk (clk),
			.en  (adv[j+1]),
			.d   (div_s[j]),
			.q   (div_s[j+1])
		);
	end

	sbps_select u_select (
		.clk (clk),
		.en  (adv[NST-1:NST-3]),
		.d   (div_s[NDIV]),
		.res (res)
	);

	assign result_valid   = vld_s[NST-1];
	assign prescale_index = res.prescale_index;
	assign scaler_index   = res.scaler_index;
	assign achieved_ratio = res.achieved_ratio;
	assign no_fit         = res.no_fit;

endmodule

[rtl/sbps_div_step.sv]
`timescale 1ns / 1ps
// One registered stage of the restoring divider: resolves two quotient bits.
// Depends on sbps_pkg.
module sbps_div_step (
	input  logic          clk,
	input  logic          en,
	input  sbps_pkg::div_t d,
	output sbps_pkg::div_t q
);

	sbps_pkg::div_t nxt;

	always_comb begin
		logic [sbps_pkg::DIV_W:0] r;
		logic                     qb;
		nxt = d;
		for (int k = 0; k < 2; k++) begin
			r = {nxt.rem, nxt.low[sbps_pkg::QUOT_W-1]};
			nxt.low = {nxt.low[sbps_pkg::QUOT_W-2:0], 1'b0};
			if (r >= {1'b0, nxt.divisor}) begin
				r  = r - {1'b0, nxt.divisor};
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			nxt.rem  = r[sbps_pkg::DIV_W-1:0];
			nxt.quot = {nxt.quot[sbps_pkg::QUOT_W-2:0], qb};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[rtl/sbps_select.sv]
`timescale 1ns / 1ps
// Three-stage pair selection: fit compare, per-scaler pick with partial min,
// final min and result formatting. Depends on sbps_pkg.
module sbps_select (
	input  logic             clk,
	input  logic [2:0]       en,
	input  sbps_pkg::div_t   d,
	output sbps_pkg::result_t res
);

	localparam int unsigned SN = sbps_pkg::SCL_N;
	localparam int unsigned PN = sbps_pkg::PRE_N;

	logic [SN-1:0][PN-1:0] fit_s1;
	sbps_pkg::cand_t       cand   [SN];
	sbps_pkg::cand_t       lvl1   [SN/2];
	sbps_pkg::cand_t       part_s2[SN/4];
	sbps_pkg::cand_t       lvl3   [2];
	sbps_pkg::cand_t       best;
	logic [sbps_pkg::NEED_W-1:0] need;

	// ceiling of the quotient
	assign need = {1'b0, d.quot} + {{(sbps_pkg::NEED_W-1){1'b0}}, |d.rem};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int s = 0; s < SN; s++) begin
				for (int p = 0; p < PN; p++) begin
					fit_s1[s][p] <= !d.ovf &&
						(need <= {1'b0, sbps_pkg::pair_product(4'(s), 2'(p))});
				end
			end
		end
	end

	// first fitting prescaler per scaler: scan down so the lowest index wins
	always_comb begin
		for (int s = 0; s < SN; s++) begin
			cand[s].ok   = 1'b0;
			cand[s].pidx = sbps_pkg::PRE_IDX_MAX;
			cand[s].sidx = 4'(s);
			cand[s].prod = '0;
			for (int p = PN - 1; p >= 0; p--) begin
				if (fit_s1[s][p]) begin
					cand[s].ok   = 1'b1;
					cand[s].pidx = 2'(p);
					cand[s].prod = sbps_pkg::pair_product(4'(s), 2'(p));
				end
			end
		end
		for (int i = 0; i < SN / 2; i++) begin
			lvl1[i] = sbps_pkg::pick(cand[2*i], cand[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < SN / 4; i++) begin
				part_s2[i] <= sbps_pkg::pick(lvl1[2*i], lvl1[2*i+1]);
			end
		end
	end

	always_comb begin
		lvl3[0] = sbps_pkg::pick(part_s2[0], part_s2[1]);
		lvl3[1] = sbps_pkg::pick(part_s2[2], part_s2[3]);
		best    = sbps_pkg::pick(lvl3[0], lvl3[1]);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (best.ok) begin
				res.prescale_index <= best.pidx;
				res.scaler_index   <= best.sidx;
				res.achieved_ratio <= best.prod;
				res.no_fit         <= 1'b0;
			end else begin
				res.prescale_index <= sbps_pkg::PRE_IDX_MAX;
				res.scaler_index   <= sbps_pkg::SCL_IDX_MAX;
				res.achieved_ratio <= '0;
				res.no_fit         <= 1'b1;
			end
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for spi_baud_prescaler_search_core: a directed table, then random
// requests under several bus clock settings, each result checked in order against a typed
// expected value or a local divide-and-search predictor. Depends on sbps_pkg and the core RTL.
module tb;

	localparam int LATENCY     = 13;
	localparam int QUIET_LIMIT = 4000;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 142;

	localparam sbps_pkg::result_t MIN_PAIR = {2'd0, 4'd0, 18'd4, 1'b0};
	localparam sbps_pkg::result_t NO_PAIR  = {sbps_pkg::PRE_IDX_MAX, sbps_pkg::SCL_IDX_MAX,
		18'd0, 1'b1};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum logic {CHK_MODEL, CHK_TYPED} row_chk_t;

	typedef struct packed {
		row_kind_t         kind;
		row_chk_t          chk;
		logic [31:0]       value;
		sbps_pkg::result_t want;
	} plan_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	logic [31:0] cfg_data     = '0;
	logic        target_valid = 1'b0;
	logic [31:0] target_hz    = '0;
	logic        result_stall = 1'b0;
	logic        target_stall;
	logic        result_valid;
	logic [1:0]  prescale_index;
	logic [3:0]  scaler_index;
	logic [17:0] achieved_ratio;
	logic        no_fit;

	logic [31:0]       bus_clock = sbps_pkg::BUS_CLK_RST;
	sbps_pkg::result_t pending_results[$];
	int                fail_count = 0;
	int                quiet_cycles = 0;
	int                stall_run = 0;
	bit                idle_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	spi_baud_prescaler_search_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.target_valid   (target_valid),
		.target_stall   (target_stall),
		.target_hz      (target_hz),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.prescale_index (prescale_index),
		.scaler_index   (scaler_index),
		.achieved_ratio (achieved_ratio),
		.no_fit         (no_fit)
	);

	function automatic logic [31:0] scaler_factor(input int s);
		if (s < 4) begin
			return 32'(2 * (s + 1));
		end
		return 32'd1 << s;
	endfunction

	function automatic logic [31:0] prescale_factor(input int p);
		case (p)
			0:       return 32'd2;
			1:       return 32'd3;
			2:       return 32'd5;
			default: return 32'd7;
		endcase
	endfunction

	// Rounded-up ratio, then per scaler the first prescaler that reaches it; keep the
	// strictly smaller product so the lower scaler index wins ties.
	function automatic sbps_pkg::result_t baud_search(input logic [31:0] bus,
			input logic [31:0] t);
		sbps_pkg::result_t r;
		logic [31:0]       need;
		logic [31:0]       prod;
		logic [31:0]       best;
		int                best_s;
		int                best_p;
		bit                found;
		bit                hit;
		found  = 1'b0;
		best   = '0;
		best_s = 0;
		best_p = 0;
		if (t != 32'd0) begin
			need = bus / t;
			if ((bus % t) != 32'd0) begin
				need = need + 32'd1;
			end
			for (int s = 0; s < 16; s++) begin
				hit = 1'b0;
				for (int p = 0; p < 4; p++) begin
					prod = scaler_factor(s) * prescale_factor(p);
					if (!hit && prod >= need) begin
						hit = 1'b1;
						if (!found || prod < best) begin
							found  = 1'b1;
							best   = prod;
							best_s = s;
							best_p = p;
						end
					end
				end
			end
		end
		if (found) begin
			r.prescale_index = 2'(best_p);
			r.scaler_index   = 4'(best_s);
			r.achieved_ratio = best[17:0];
			r.no_fit         = 1'b0;
		end else begin
			r = NO_PAIR;
		end
		return r;
	endfunction

	function automatic plan_row_t plan_row(input row_kind_t k, input row_chk_t c,
			input logic [31:0] v, input sbps_pkg::result_t w);
		plan_row_t r;
		r.kind  = k;
		r.chk   = c;
		r.value = v;
		r.want  = w;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Mostly requests whose ratio lands in the searchable range or right on a pair product.
	function automatic logic [31:0] random_target(input logic [31:0] bus);
		int          r;
		logic [31:0] t;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			t = '0;
		end else if (r < 20) begin
			t = $urandom;
		end else if (r < 30) begin
			t = $urandom_range(1, 16);
		end else if (r < 70) begin
			t = bus / (scaler_factor($urandom_range(0, 15))
				* prescale_factor($urandom_range(0, 3)));
			t = t + $urandom_range(0, 2) - 1;
		end else begin
			t = bus / $urandom_range(1, 240000);
		end
		if (r >= 20 && t == 32'd0) begin
			t = 32'd1;
		end
		return t;
	endfunction

	task automatic send_target(input logic [31:0] t, input row_chk_t chk,
			input sbps_pkg::result_t want);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		repeat (gap) begin
			target_valid <= 1'b0;
			@(negedge clk);
		end
		target_valid <= 1'b1;
		target_hz    <= t;
		do @(posedge clk); while (target_stall);
		pending_results.push_back((chk == CHK_TYPED) ? want : baud_search(bus_clock, t));
	endtask

	// Write only with the pipeline drained.
	task automatic write_bus_clock(input logic [31:0] v);
		@(negedge clk);
		target_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		bus_clock = v;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (stall_run == 0 && idle_on && $urandom_range(0, 4) == 0) begin
				stall_run = pick_gap();
			end
			result_stall <= (stall_run != 0);
			if (stall_run != 0) begin
				stall_run--;
			end
		end
	end

	always @(posedge clk) begin
		sbps_pkg::result_t got;
		sbps_pkg::result_t want;
		bit                bad;
		if (arst_n && result_valid && !result_stall) begin
			got = {prescale_index, scaler_index, achieved_ratio, no_fit};
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: unexpected result pre=%0d scl=%0d ratio=%0d no_fit=%0b",
						$realtime, got.prescale_index, got.scaler_index,
						got.achieved_ratio, got.no_fit);
				end
			end else begin
				want = pending_results.pop_front();
				bad = (got.prescale_index !== want.prescale_index)
					|| (got.scaler_index !== want.scaler_index)
					|| (got.achieved_ratio !== want.achieved_ratio)
					|| (got.no_fit !== want.no_fit);
				if (bad) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("%0t: mismatch exp pre=%0d scl=%0d ratio=%0d no_fit=%0b,",
							$realtime, want.prescale_index, want.scaler_index,
							want.achieved_ratio, want.no_fit);
						$display(" got pre=%0d scl=%0d ratio=%0d no_fit=%0b",
							got.prescale_index, got.scaler_index,
							got.achieved_ratio, got.no_fit);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((target_valid && !target_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t   plan[$];
		logic [31:0] bus_pick;
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd0, NO_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'hFFFF_FFFF, MIN_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd25000000, MIN_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd20000000, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd1, NO_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd435, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd436, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd1000000, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd3333, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd16, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd2, '0));
		// zero bus clock: every pair fits unless the target is zero
		plan.push_back(plan_row(ROW_CFG, CHK_MODEL, 32'd0, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd1, MIN_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd0, NO_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'hFFFF_FFFF, MIN_PAIR));
		plan.push_back(plan_row(ROW_CFG, CHK_MODEL, 32'd1, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd1, MIN_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'h8000_0000, '0));
		plan.push_back(plan_row(ROW_CFG, CHK_MODEL, 32'hFFFF_FFFF, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'd1, NO_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_TYPED, 32'hFFFF_FFFF, MIN_PAIR));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd18724, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd18725, '0));
		plan.push_back(plan_row(ROW_ITEM, CHK_MODEL, 32'd65536, '0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_bus_clock(plan[i].value);
			end else begin
				send_target(plan[i].value, plan[i].chk, plan[i].want);
			end
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0:       bus_pick = sbps_pkg::BUS_CLK_RST;
				2:       bus_pick = $urandom_range(1, 4096);
				3:       bus_pick = 32'hFFFF_FFFF;
				4:       bus_pick = 32'd1;
				default: bus_pick = $urandom;
			endcase
			write_bus_clock(bus_pick);
			// one phase runs back to back on both sides
			idle_on = (phase != 2);
			repeat (PHASE_ITEMS) begin
				send_target(random_target(bus_clock), CHK_MODEL, '0);
			end
		end

		@(negedge clk);
		target_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
